// ----- rtl/core/pcap_pkg.sv -----
// pcap_pkg: shared types and constants for the pulse counted axis positioner
// no dependencies; used by the channel interfaces and the core

package pcap_pkg;

   localparam int unsigned POS_W   = 16;
   localparam int unsigned SPEED_W = 10;
   localparam int unsigned OP_W    = 3;
   localparam int unsigned DRIVE_W = 2;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 16;

   localparam logic [SPEED_W-1:0] SPEED_LIMIT = SPEED_W'(512);
   localparam logic [POS_W-1:0]   MAX_POSITION_RESET = '1;

   // command codes
   localparam logic [OP_W-1:0] OP_TICK     = 3'd0;
   localparam logic [OP_W-1:0] OP_HOME     = 3'd1;
   localparam logic [OP_W-1:0] OP_MOVE_ABS = 3'd2;
   localparam logic [OP_W-1:0] OP_MOVE_REL = 3'd3;
   localparam logic [OP_W-1:0] OP_STOP     = 3'd4;

   // motor drive codes
   localparam logic [DRIVE_W-1:0] DRIVE_STOP  = 2'd0;
   localparam logic [DRIVE_W-1:0] DRIVE_LEFT  = 2'd1;
   localparam logic [DRIVE_W-1:0] DRIVE_RIGHT = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_DRIVE_SPEED     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_REF_ACTIVE_HIGH = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_POSITION    = 2'd2;

   typedef enum logic [2:0] {
      MODE_UNREF = 3'd0,
      MODE_READY = 3'd1,
      MODE_LEFT  = 3'd2,
      MODE_RIGHT = 3'd3,
      MODE_HOME  = 3'd4
   } mode_type;

endpackage

// ----- rtl/core/pcap_req_if.sv -----
// pcap_req_if: request channel carrying one tick with an optional command
// depends on pcap_pkg for field widths

interface pcap_req_if;
   logic                        valid;
   logic                        ready;
   logic [pcap_pkg::OP_W-1:0]   op;
   logic [pcap_pkg::POS_W-1:0]  target_position;
   logic signed [pcap_pkg::POS_W-1:0] move_distance;
   logic                        ref_switch;
   logic                        count_pulse;

   modport source (output valid, op, target_position, move_distance, ref_switch,
                   count_pulse, input ready);
   modport sink   (input valid, op, target_position, move_distance, ref_switch,
                   count_pulse, output ready);
endinterface

// ----- rtl/core/pcap_rsp_if.sv -----
// pcap_rsp_if: response channel carrying drive, speed, position and status
// depends on pcap_pkg for field widths

interface pcap_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [pcap_pkg::DRIVE_W-1:0]  motor_drive;
   logic [pcap_pkg::SPEED_W-1:0]  motor_speed;
   logic [pcap_pkg::POS_W-1:0]    current_position;
   logic [2:0]                    axis_status;
   logic                          command_accepted;

   modport source (output valid, motor_drive, motor_speed, current_position,
                   axis_status, command_accepted, input ready);
   modport sink   (input valid, motor_drive, motor_speed, current_position,
                   axis_status, command_accepted, output ready);
endinterface

// ----- rtl/core/pulse_counted_axis_positioner_core.sv -----
// pulse_counted_axis_positioner_core: single-axis homing and positioning core
// depends on pcap_pkg, pcap_req_if and pcap_rsp_if
//
// channel   | direction | contents
// req_chan  | in        | op, target_position, move_distance, ref_switch, count_pulse
// rsp_chan  | out       | motor_drive, motor_speed, current_position, axis_status,
//           |           | command_accepted
// csr_*     | in        | write enable, register index, write data (no read-back)
//
// one request per clock unless stalled; the registered response shows in the next cycle
// the axis state and the response register update together at the accepting edge,
// so the next tick sees the updated position and mode at once
// req_chan.ready is high whenever the response register is empty or being drained,
// so a held response stalls only the following request
// reset is synchronous: axis unreferenced, position and destination zero, registers at defaults

module pulse_counted_axis_positioner_core (
   input  logic                                 clock,
   input  logic                                 reset,
   pcap_req_if.sink                             req_chan,
   pcap_rsp_if.source                           rsp_chan,
   input  logic                                 csr_write_enable,
   input  logic [pcap_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [pcap_pkg::CSR_DATA_W-1:0]      csr_write_data
);

   localparam int unsigned PW = pcap_pkg::POS_W;

   // configuration registers
   logic [pcap_pkg::SPEED_W-1:0] drive_speed_ff;
   logic                         ref_active_high_ff;
   logic [PW-1:0]                max_position_ff;

   // axis state
   logic [PW-1:0]          position_ff, position_in;
   logic [PW-1:0]          destination_ff, destination_in;
   pcap_pkg::mode_type     mode_ff, mode_in;

   // response register
   logic                             rsp_valid_ff;
   logic [pcap_pkg::DRIVE_W-1:0]     drive_ff, drive_in;
   logic [pcap_pkg::SPEED_W-1:0]     speed_ff, speed_in;
   logic                             accepted_ff, accepted_in;

   localparam int unsigned SPEED_W_LOC = pcap_pkg::SPEED_W;
   logic                  req_fire;
   logic [SPEED_W_LOC-1:0] csr_speed;

   // command stage signals
   logic [PW+1:0]         rel_sum;
   logic                  rel_in_range;
   logic [PW-1:0]         move_target;
   logic                  move_ok;
   logic                  was_moving;
   pcap_pkg::mode_type    mode_cmd;
   logic                  switch_active;
   logic [PW-1:0]         position_step;

   assign req_fire       = req_chan.valid && req_chan.ready;
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;

   // configuration writes; an oversized speed is dropped
   assign csr_speed = csr_write_data[SPEED_W_LOC-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         drive_speed_ff     <= pcap_pkg::SPEED_LIMIT;
         ref_active_high_ff <= 1'b1;
         max_position_ff    <= pcap_pkg::MAX_POSITION_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            pcap_pkg::CSR_DRIVE_SPEED: begin
               if (csr_speed <= pcap_pkg::SPEED_LIMIT) drive_speed_ff <= csr_speed;
            end
            pcap_pkg::CSR_REF_ACTIVE_HIGH: ref_active_high_ff <= csr_write_data[0];
            pcap_pkg::CSR_MAX_POSITION:    max_position_ff    <= csr_write_data[PW-1:0];
            default: ;
         endcase
      end
   end

   // relative target without wrap: two guard bits catch below zero and beyond range
   assign rel_sum = {2'b00, position_ff}
                  + {{2{req_chan.move_distance[PW-1]}}, req_chan.move_distance};
   assign rel_in_range = !rel_sum[PW+1] && (rel_sum[PW:0] <= {1'b0, max_position_ff});

   assign move_target = (req_chan.op == pcap_pkg::OP_MOVE_ABS) ? req_chan.target_position
                                                                : rel_sum[PW-1:0];
   assign switch_active = (req_chan.ref_switch == ref_active_high_ff);

   always_comb begin
      // command first
      mode_cmd       = mode_ff;
      destination_in = destination_ff;
      accepted_in    = 1'b0;
      was_moving     = (mode_ff == pcap_pkg::MODE_LEFT) || (mode_ff == pcap_pkg::MODE_RIGHT);
      move_ok        = 1'b0;

      unique case (req_chan.op)
         pcap_pkg::OP_HOME: begin
            mode_cmd    = pcap_pkg::MODE_HOME;
            was_moving  = 1'b0;
            accepted_in = 1'b1;
         end
         pcap_pkg::OP_MOVE_ABS: begin
            move_ok = (mode_ff == pcap_pkg::MODE_READY)
                    && (req_chan.target_position <= max_position_ff);
         end
         pcap_pkg::OP_MOVE_REL: begin
            move_ok = (mode_ff == pcap_pkg::MODE_READY) && rel_in_range;
         end
         pcap_pkg::OP_STOP: begin
            if (was_moving) mode_cmd = pcap_pkg::MODE_READY;
            else if (mode_ff == pcap_pkg::MODE_HOME) mode_cmd = pcap_pkg::MODE_UNREF;
            was_moving  = 1'b0;
            accepted_in = 1'b1;
         end
         default: ;
      endcase

      if (move_ok) begin
         accepted_in    = 1'b1;
         destination_in = move_target;
         if (position_ff > move_target)      mode_cmd = pcap_pkg::MODE_LEFT;
         else if (position_ff < move_target) mode_cmd = pcap_pkg::MODE_RIGHT;
      end

      // then motion
      mode_in       = mode_cmd;
      position_in   = position_ff;
      position_step = (mode_cmd == pcap_pkg::MODE_LEFT) ? position_ff - PW'(1)
                                                        : position_ff + PW'(1);
      if (mode_cmd == pcap_pkg::MODE_HOME) begin
         if (switch_active) begin
            position_in = '0;
            mode_in     = pcap_pkg::MODE_READY;
         end
      end else if (was_moving && req_chan.count_pulse) begin
         if ((mode_cmd == pcap_pkg::MODE_LEFT) || (mode_cmd == pcap_pkg::MODE_RIGHT)) begin
            position_in = position_step;
         end
         if (position_in == destination_in) mode_in = pcap_pkg::MODE_READY;
      end

      // motor outputs follow the final mode
      priority if ((mode_in == pcap_pkg::MODE_LEFT) || (mode_in == pcap_pkg::MODE_HOME)) begin
         drive_in = pcap_pkg::DRIVE_LEFT;
      end else if (mode_in == pcap_pkg::MODE_RIGHT) begin
         drive_in = pcap_pkg::DRIVE_RIGHT;
      end else begin
         drive_in = pcap_pkg::DRIVE_STOP;
      end
      speed_in = (drive_in == pcap_pkg::DRIVE_STOP) ? '0 : drive_speed_ff;
   end

   // axis state register
   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff    <= '0;
         destination_ff <= '0;
         mode_ff        <= pcap_pkg::MODE_UNREF;
      end else if (req_fire) begin
         position_ff    <= position_in;
         destination_ff <= destination_in;
         mode_ff        <= mode_in;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         drive_ff    <= drive_in;
         speed_ff    <= speed_in;
         accepted_ff <= accepted_in;
      end
   end

   // position and status in the response are the state just written
   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.motor_drive      = drive_ff;
   assign rsp_chan.motor_speed      = speed_ff;
   assign rsp_chan.current_position = position_ff;
   assign rsp_chan.axis_status      = 3'(mode_ff);
   assign rsp_chan.command_accepted = accepted_ff;

   // checks
   a_accept_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> rsp_valid_ff)
      else $error("accepted request did not produce a response");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff |-> req_chan.ready)
      else $error("request stalled with empty response register");

   a_speed_limit: assert property (@(posedge clock) disable iff (reset)
      drive_speed_ff <= pcap_pkg::SPEED_LIMIT)
      else $error("drive speed above limit");

   a_stopped_no_speed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (drive_ff == pcap_pkg::DRIVE_STOP) |-> (speed_ff == '0))
      else $error("speed driven while motor stopped");

   a_home_zeroes: assert property (@(posedge clock) disable iff (reset)
      ($past(mode_ff) == pcap_pkg::MODE_HOME) && (mode_ff == pcap_pkg::MODE_READY)
      |-> (position_ff == '0))
      else $error("homing finished with non-zero position");

endmodule

// ----- verif/tb_pulse_counted_axis_positioner_core.sv -----
// tb_pulse_counted_axis_positioner_core: self-checking bench for the axis positioner core
// depends on pcap_pkg, pcap_req_if, pcap_rsp_if and pulse_counted_axis_positioner_core
// ticks go in through a queued driver, responses are checked against an in-bench axis predictor

module tb_pulse_counted_axis_positioner_core;

   localparam int unsigned PW = pcap_pkg::POS_W;
   localparam int unsigned OW = pcap_pkg::OP_W;
   localparam int unsigned SW = pcap_pkg::SPEED_W;
   localparam int unsigned DW = pcap_pkg::CSR_DATA_W;
   localparam int unsigned IW = pcap_pkg::CSR_IDX_W;

   // op codes the core ignores
   localparam logic [OW-1:0] OP_SPARE_LO = 3'd5;
   localparam logic [OW-1:0] OP_SPARE_HI = 3'd7;
   // register index with nothing behind it
   localparam logic [IW-1:0] CSR_UNUSED  = 2'd3;

   localparam int unsigned IDLE_PCT       = 14;
   localparam int unsigned HOLD_AT        = 120;
   localparam int unsigned HOLD_LEN       = 50;
   localparam int unsigned WATCHDOG_LIMIT = 2000;

   typedef struct packed {
      logic [OW-1:0]        op;
      logic [PW-1:0]        target;
      logic signed [PW-1:0] distance;
      logic                 ref_switch;
      logic                 count_pulse;
   } axis_tick_type;

   typedef struct packed {
      logic [pcap_pkg::DRIVE_W-1:0] drive;
      logic [SW-1:0]                speed;
      logic [PW-1:0]                position;
      pcap_pkg::mode_type           status;
      logic                         accepted;
   } axis_report_type;

   logic          clock;
   logic          reset;
   logic          csr_write_enable;
   logic [IW-1:0] csr_index;
   logic [DW-1:0] csr_write_data;

   pcap_req_if req_chan();
   pcap_rsp_if rsp_chan();

   pulse_counted_axis_positioner_core u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // predictor copy of the registers and axis state
   logic [SW-1:0]      drive_speed = pcap_pkg::SPEED_LIMIT;
   logic               ref_active  = 1'b1;
   logic [PW-1:0]      max_pos     = pcap_pkg::MAX_POSITION_RESET;
   logic [PW-1:0]      axis_pos    = '0;
   logic [PW-1:0]      axis_dest   = '0;
   pcap_pkg::mode_type axis_mode   = pcap_pkg::MODE_UNREF;

   axis_tick_type   pending_ticks[$];
   axis_report_type expected_reports[$];
   axis_tick_type   offered;

   int unsigned queued_ticks    = 0;
   int unsigned checked_reports = 0;
   int unsigned error_count     = 0;
   int unsigned hold_left       = 0;
   int unsigned quiet_cycles    = 0;
   bit          hold_done       = 1'b0;
   bit          gaps_on         = 1'b1;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------------------------------
   // axis predictor
   // ---------------------------------------------------------------------------------------

   // a move starts only from ready and within range; a move onto the current
   // position is taken but leaves the axis ready
   function automatic bit try_move(logic [PW-1:0] goal);
      if (axis_mode != pcap_pkg::MODE_READY || goal > max_pos)
         return 1'b0;
      axis_dest = goal;
      if (axis_pos > goal)
         axis_mode = pcap_pkg::MODE_LEFT;
      else if (axis_pos < goal)
         axis_mode = pcap_pkg::MODE_RIGHT;
      return 1'b1;
   endfunction

   // one tick: command first, then motion, then the outputs
   function automatic axis_report_type advance_axis(axis_tick_type t);
      axis_report_type r;
      logic            was_moving;
      logic            taken;
      int              goal;
      was_moving = (axis_mode == pcap_pkg::MODE_LEFT || axis_mode == pcap_pkg::MODE_RIGHT);
      taken      = 1'b0;
      case (t.op)
         pcap_pkg::OP_HOME: begin
            // homing aborts any move and is always taken
            axis_mode  = pcap_pkg::MODE_HOME;
            was_moving = 1'b0;
            taken      = 1'b1;
         end
         pcap_pkg::OP_MOVE_ABS: taken = try_move(t.target);
         pcap_pkg::OP_MOVE_REL: begin
            // target worked out without wrap, outside 0..max_pos is refused
            goal = int'(axis_pos) + int'($signed(t.distance));
            if (goal >= 0 && goal <= int'(max_pos))
               taken = try_move(PW'(goal));
         end
         pcap_pkg::OP_STOP: begin
            if (axis_mode == pcap_pkg::MODE_LEFT || axis_mode == pcap_pkg::MODE_RIGHT)
               axis_mode = pcap_pkg::MODE_READY;
            else if (axis_mode == pcap_pkg::MODE_HOME)
               axis_mode = pcap_pkg::MODE_UNREF;
            was_moving = 1'b0;
            taken      = 1'b1;
         end
         default: ;
      endcase

      if (axis_mode == pcap_pkg::MODE_HOME) begin
         // switch is tested in the very tick that homing starts
         if ((ref_active && t.ref_switch) || (!ref_active && !t.ref_switch)) begin
            axis_pos  = '0;
            axis_mode = pcap_pkg::MODE_READY;
         end
      end else if (was_moving && t.count_pulse) begin
         // the tick that starts a move never counts
         if (axis_mode == pcap_pkg::MODE_LEFT)
            axis_pos = axis_pos - 1'b1;
         else if (axis_mode == pcap_pkg::MODE_RIGHT)
            axis_pos = axis_pos + 1'b1;
         if (axis_pos == axis_dest)
            axis_mode = pcap_pkg::MODE_READY;
      end

      if (axis_mode == pcap_pkg::MODE_LEFT || axis_mode == pcap_pkg::MODE_HOME)
         r.drive = pcap_pkg::DRIVE_LEFT;
      else if (axis_mode == pcap_pkg::MODE_RIGHT)
         r.drive = pcap_pkg::DRIVE_RIGHT;
      else
         r.drive = pcap_pkg::DRIVE_STOP;
      r.speed    = (r.drive != pcap_pkg::DRIVE_STOP) ? drive_speed : '0;
      r.position = axis_pos;
      r.status   = axis_mode;
      r.accepted = taken;
      return r;
   endfunction

   // ---------------------------------------------------------------------------------------
   // request driver: offers queued ticks, predicts each one as its transaction completes
   // ---------------------------------------------------------------------------------------

   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else begin
         if (req_chan.valid && req_chan.ready)
            expected_reports = {expected_reports, advance_axis(offered)};
         if (!req_chan.valid || req_chan.ready) begin
            if (pending_ticks.size() != 0 && !(gaps_on && $urandom_range(99) < IDLE_PCT)) begin
               offered                  = pending_ticks.pop_front();
               req_chan.op              <= offered.op;
               req_chan.target_position <= offered.target;
               req_chan.move_distance   <= offered.distance;
               req_chan.ref_switch      <= offered.ref_switch;
               req_chan.count_pulse     <= offered.count_pulse;
               req_chan.valid           <= 1'b1;
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------------------------
   // response monitor: checks every transaction against the oldest prediction
   // ---------------------------------------------------------------------------------------

   function automatic void check_field(string field, int want, int got);
      if (want != got) begin
         $display("%0t: %s expected %0d got %0d", $time, field, want, got);
         error_count++;
      end
   endfunction

   always @(posedge clock) begin
      axis_report_type want;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_reports.size() == 0) begin
               $display("%0t: response with nothing predicted, position %0d status %0d",
                        $time, rsp_chan.current_position, rsp_chan.axis_status);
               error_count++;
            end else begin
               want = expected_reports.pop_front();
               check_field("motor_drive", int'(want.drive), int'(rsp_chan.motor_drive));
               check_field("motor_speed", int'(want.speed), int'(rsp_chan.motor_speed));
               check_field("current_position", int'(want.position),
                           int'(rsp_chan.current_position));
               check_field("axis_status", int'(want.status), int'(rsp_chan.axis_status));
               check_field("command_accepted", int'(want.accepted),
                           int'(rsp_chan.command_accepted));
            end
            checked_reports++;
         end
         // one long hold-off so the response register fills and the input stalls
         if (hold_left != 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else if (!hold_done && checked_reports >= HOLD_AT) begin
            hold_done = 1'b1;
            hold_left = HOLD_LEN;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= !(gaps_on && $urandom_range(99) < IDLE_PCT);
         end
      end
   end

   // watchdog on cycles in which neither channel moves a transaction
   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("tb_pulse_counted_axis_positioner_core: errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------------------------------

   function automatic logic [PW-1:0] rnd_word();
      return PW'($urandom());
   endfunction

   function automatic logic rnd_bit();
      return 1'($urandom_range(1));
   endfunction

   function automatic void queue_tick(logic [OW-1:0] op, logic [PW-1:0] target,
                                      logic [PW-1:0] distance, logic sw, logic pulse);
      axis_tick_type t;
      t.op          = op;
      t.target      = target;
      t.distance    = distance;
      t.ref_switch  = sw;
      t.count_pulse = pulse;
      pending_ticks = {pending_ticks, t};
      queued_ticks++;
   endfunction

   // raw switch level that reads active or inactive under the present polarity
   function automatic logic switch_level(bit active);
      return active ? ref_active : !ref_active;
   endfunction

   // register write; the predictor takes it at the same edge as the core
   task automatic write_reg(logic [IW-1:0] index, logic [DW-1:0] data);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      case (index)
         pcap_pkg::CSR_DRIVE_SPEED: begin
            // speeds above the limit are dropped
            if (data[SW-1:0] <= pcap_pkg::SPEED_LIMIT)
               drive_speed = data[SW-1:0];
         end
         pcap_pkg::CSR_REF_ACTIVE_HIGH: ref_active = data[0];
         pcap_pkg::CSR_MAX_POSITION:    max_pos    = data[PW-1:0];
         default: ;
      endcase
   endtask

   // sender pause: nothing queued, nothing on the bus, nothing outstanding
   task automatic wait_idle();
      while (pending_ticks.size() != 0 || req_chan.valid || expected_reports.size() != 0)
         @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   // random part: mostly well-formed homing and move sequences, some noise
   task automatic queue_random(int unsigned count);
      int unsigned   stop_at;
      int unsigned   roll;
      int unsigned   span;
      int            step;
      logic [PW-1:0] goal;
      stop_at = queued_ticks + count;
      while (queued_ticks < stop_at) begin
         roll = $urandom_range(99);
         if (roll < 12) begin
            // homing: a few ticks off the switch, then onto it
            queue_tick(pcap_pkg::OP_HOME, rnd_word(), rnd_word(),
                       switch_level($urandom_range(3) == 0), rnd_bit());
            span = $urandom_range(6);
            repeat (span)
               queue_tick(pcap_pkg::OP_TICK, rnd_word(), rnd_word(), switch_level(1'b0),
                          rnd_bit());
            queue_tick(pcap_pkg::OP_TICK, rnd_word(), rnd_word(), switch_level(1'b1),
                       rnd_bit());
         end else if (roll < 50) begin
            // short relative move, then enough ticks to arrive most of the time
            step = int'($urandom_range(30));
            if ($urandom_range(1) != 0)
               step = -step;
            queue_tick(pcap_pkg::OP_MOVE_REL, rnd_word(), PW'(step), rnd_bit(), rnd_bit());
            span = ((step < 0) ? -step : step) + $urandom_range(8);
            repeat (span)
               queue_tick(pcap_pkg::OP_TICK, rnd_word(), rnd_word(), rnd_bit(),
                          $urandom_range(9) < 8);
         end else if (roll < 72) begin
            // absolute move, mostly near the origin, now and then far or at the limit
            span = $urandom_range(19);
            if (span == 0)
               goal = max_pos;
            else if (span < 3)
               goal = rnd_word();
            else
               goal = PW'($urandom_range(50));
            queue_tick(pcap_pkg::OP_MOVE_ABS, goal, rnd_word(), rnd_bit(), rnd_bit());
            span = $urandom_range(5, 45);
            repeat (span)
               queue_tick(pcap_pkg::OP_TICK, rnd_word(), rnd_word(), rnd_bit(),
                          $urandom_range(9) < 8);
         end else if (roll < 82) begin
            queue_tick(pcap_pkg::OP_STOP, rnd_word(), rnd_word(), rnd_bit(), rnd_bit());
         end else begin
            // noise: any op code, any field value
            span = $urandom_range(1, 4);
            repeat (span)
               queue_tick(OW'($urandom_range(7)), rnd_word(), rnd_word(), rnd_bit(),
                          rnd_bit());
         end
      end
   endtask

   // ---------------------------------------------------------------------------------------
   // test sequence
   // ---------------------------------------------------------------------------------------

   initial begin
      reset                    = 1'b1;
      csr_write_enable         = 1'b0;
      csr_index                = '0;
      csr_write_data           = '0;
      req_chan.valid           = 1'b0;
      req_chan.op              = pcap_pkg::OP_TICK;
      req_chan.target_position = '0;
      req_chan.move_distance   = '0;
      req_chan.ref_switch      = 1'b0;
      req_chan.count_pulse     = 1'b0;
      rsp_chan.ready           = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed part under reset defaults (switch active high)
      // idle while unreferenced
      queue_tick(pcap_pkg::OP_TICK,     16'd0,    16'd0,    1'b1, 1'b1);
      // refused, not referenced
      queue_tick(pcap_pkg::OP_MOVE_ABS, 16'd5,    16'd0,    1'b0, 1'b0);
      // stop leaves unreferenced
      queue_tick(pcap_pkg::OP_STOP,     16'd0,    16'd0,    1'b0, 1'b0);
      // homing, drive left
      queue_tick(pcap_pkg::OP_HOME,     16'd0,    16'd0,    1'b0, 1'b0);
      // pulses ignored while homing
      queue_tick(pcap_pkg::OP_TICK,     16'd0,    16'd0,    1'b0, 1'b1);
      // stop homing, unreferenced
      queue_tick(pcap_pkg::OP_STOP,     16'd0,    16'd0,    1'b0, 1'b0);
      // switch already active
      queue_tick(pcap_pkg::OP_HOME,     16'hFFFF, 16'hFFFF, 1'b1, 1'b1);
      // below zero, refused
      queue_tick(pcap_pkg::OP_MOVE_REL, 16'd0,    PW'(-1),  1'b0, 1'b0);
      // move onto itself
      queue_tick(pcap_pkg::OP_MOVE_ABS, 16'd0,    16'd0,    1'b0, 1'b1);
      // far right, start no count
      queue_tick(pcap_pkg::OP_MOVE_ABS, 16'hFFFF, 16'd0,    1'b0, 1'b1);
      queue_tick(pcap_pkg::OP_TICK,     16'd0,    16'd0,    1'b0, 1'b1);
      queue_tick(pcap_pkg::OP_TICK,     16'd0,    16'd0,    1'b1, 1'b0);
      // refused while moving
      queue_tick(pcap_pkg::OP_MOVE_ABS, 16'd3,    16'd0,    1'b0, 1'b1);
      // moving back to ready
      queue_tick(pcap_pkg::OP_STOP,     16'd0,    16'd0,    1'b0, 1'b1);
      // largest positive offset
      queue_tick(pcap_pkg::OP_MOVE_REL, 16'd0,    16'h7FFF, 1'b0, 1'b0);
      // homing aborts the move
      queue_tick(pcap_pkg::OP_HOME,     16'd0,    16'd0,    1'b0, 1'b1);
      queue_tick(pcap_pkg::OP_TICK,     16'd0,    16'd0,    1'b1, 1'b1);
      // most negative offset
      queue_tick(pcap_pkg::OP_MOVE_REL, 16'd0,    16'h8000, 1'b0, 1'b0);
      queue_tick(pcap_pkg::OP_MOVE_REL, 16'd0,    16'd2,    1'b0, 1'b1);
      queue_tick(pcap_pkg::OP_TICK,     16'd0,    16'd0,    1'b0, 1'b1);
      // arrival
      queue_tick(pcap_pkg::OP_TICK,     16'd0,    16'd0,    1'b0, 1'b1);
      queue_tick(pcap_pkg::OP_MOVE_REL, 16'd0,    PW'(-2),  1'b0, 1'b1);
      queue_tick(pcap_pkg::OP_TICK,     16'd0,    16'd0,    1'b0, 1'b1);
      // no command, still counts
      queue_tick(OP_SPARE_HI,           16'hFFFF, 16'hFFFF, 1'b1, 1'b1);
      queue_tick(OP_SPARE_LO,           16'd0,    16'd0,    1'b0, 1'b0);
      wait_idle();

      // opener switch, tight range, out-of-limit speeds dropped, spare index ignored
      write_reg(pcap_pkg::CSR_DRIVE_SPEED, 16'd1023);
      write_reg(pcap_pkg::CSR_DRIVE_SPEED, 16'd513);
      write_reg(CSR_UNUSED, 16'hFFFF);
      write_reg(pcap_pkg::CSR_MAX_POSITION, 16'd40);
      write_reg(pcap_pkg::CSR_REF_ACTIVE_HIGH, 16'd0);
      queue_random(200);
      wait_idle();

      // zero speed and a range of one position
      write_reg(pcap_pkg::CSR_DRIVE_SPEED, 16'd0);
      write_reg(pcap_pkg::CSR_MAX_POSITION, 16'd0);
      write_reg(pcap_pkg::CSR_REF_ACTIVE_HIGH, 16'd1);
      queue_random(80);
      wait_idle();

      // full range, full speed with upper data bits set, no gaps on either side
      write_reg(pcap_pkg::CSR_DRIVE_SPEED, 16'hFE00);
      write_reg(pcap_pkg::CSR_MAX_POSITION, 16'hFFFF);
      write_reg(pcap_pkg::CSR_REF_ACTIVE_HIGH, 16'hFFFE);
      gaps_on = 1'b0;
      queue_random(200);
      wait_idle();
      gaps_on = 1'b1;

      // mid-range settings
      write_reg(pcap_pkg::CSR_DRIVE_SPEED, DW'($urandom_range(1, 511)));
      write_reg(pcap_pkg::CSR_MAX_POSITION, DW'($urandom_range(20, 100)));
      write_reg(pcap_pkg::CSR_REF_ACTIVE_HIGH, 16'd1);
      queue_random(140);
      wait_idle();

      // let any stray response show before the verdict
      repeat (4) @(posedge clock);
      if (error_count == 0)
         $display("tb_pulse_counted_axis_positioner_core: clean");
      else
         $display("tb_pulse_counted_axis_positioner_core: errors");
      $finish;
   end

endmodule
